@@ hdl/zefp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zefp_pkg
// shared types, record ids and the timestamp slot layout for the zip extra
// field parser
// ----------------------------------------------------------------------------
package zefp_pkg;

    localparam int LENGTH_BITS_DEF = 16;

    localparam logic [15:0] ID_STAMP = 16'h5455;
    localparam logic [15:0] ID_UNIX  = 16'h7875;

    localparam int NUM_STAMPS = 3;

    typedef struct packed {
        logic [2:0]       present;
        logic [2:0][3:0]  start;
    } t_slots;

    typedef struct packed {
        logic [2:0]        stamp_take;
        logic [2:0][31:0]  stamp_val;
        logic              unix_take;
        logic [31:0]       uid;
        logic [31:0]       gid;
    } t_commit;

    typedef struct packed {
        logic [31:0] mod_time;
        logic [31:0] acc_time;
        logic [31:0] cre_time;
        logic        has_mod_time;
        logic        has_acc_time;
        logic        has_cre_time;
        logic        has_unix_ids;
        logic [31:0] user_id;
        logic [31:0] group_id;
    } t_result;

    // where each time sits in the payload; a missing time moves the next up
    function automatic t_slots stamp_slots(input logic [7:0] flags, input logic [15:0] size);
        t_slots     s;
        logic [3:0] off;
        off = 4'd1;
        for (int k = 0; k < NUM_STAMPS; k++) begin
            s.start[k]   = off;
            s.present[k] = flags[k] && ({12'h000, off} + 16'd4 <= size);
            if (s.present[k]) begin
                off = off + 4'd4;
            end
        end
        return s;
    endfunction

endpackage

@@ hdl/zefp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zefp_if
// byte input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface zefp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface zefp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] mod_time;
    logic [31:0] acc_time;
    logic [31:0] cre_time;
    logic        has_mod_time;
    logic        has_acc_time;
    logic        has_cre_time;
    logic        has_unix_ids;
    logic [31:0] user_id;
    logic [31:0] group_id;

    modport source (
        output valid, input ready,
        output mod_time, output acc_time, output cre_time,
        output has_mod_time, output has_acc_time, output has_cre_time,
        output has_unix_ids, output user_id, output group_id
    );
    modport sink (
        input valid, output ready,
        input mod_time, input acc_time, input cre_time,
        input has_mod_time, input has_acc_time, input has_cre_time,
        input has_unix_ids, input user_id, input group_id
    );
endinterface

@@ hdl/zip_extra_field_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zip_extra_field_parser_core
// result: registered, valid in the cycle after the last byte is accepted
// throughput: one byte per cycle; input ready drops only while a finished
//   result sits in the output register and the sink is not ready
// reset: synchronous, clears the record walker, committed values and the
//   output valid flag; no clearing pass
// ----------------------------------------------------------------------------
module zip_extra_field_parser_core #(
    parameter int LENGTH_BITS = zefp_pkg::LENGTH_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    zefp_in_if.sink    i_in,
    zefp_out_if.source o_out
);

    logic              take;
    logic              emit;
    logic              can_load;
    logic              out_valid;
    zefp_pkg::t_commit commit;
    zefp_pkg::t_result result;
    zefp_pkg::t_result out_result;

    assign i_in.ready = can_load;
    assign take       = i_in.valid && can_load;

    zefp_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_commit    (commit)
    );

    zefp_commit u_commit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_last_byte (i_in.last_byte),
        .i_commit    (commit),
        .o_emit      (emit),
        .o_result    (result)
    );

    zefp_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (emit),
        .i_result   (result),
        .i_ready    (o_out.ready),
        .o_valid    (out_valid),
        .o_can_load (can_load),
        .o_result   (out_result)
    );

    assign o_out.valid        = out_valid;
    assign o_out.mod_time     = out_result.mod_time;
    assign o_out.acc_time     = out_result.acc_time;
    assign o_out.cre_time     = out_result.cre_time;
    assign o_out.has_mod_time = out_result.has_mod_time;
    assign o_out.has_acc_time = out_result.has_acc_time;
    assign o_out.has_cre_time = out_result.has_cre_time;
    assign o_out.has_unix_ids = out_result.has_unix_ids;
    assign o_out.user_id      = out_result.user_id;
    assign o_out.group_id     = out_result.group_id;

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(take && i_in.last_byte))
        else $error("result beat without an accepted last byte");

endmodule

@@ hdl/zefp_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zefp_parser
// record walker: header bytes, payload offset, pending record values and the
// commit decision on the final payload byte of each record
// ----------------------------------------------------------------------------
module zefp_parser #(
    parameter int LENGTH_BITS = zefp_pkg::LENGTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output zefp_pkg::t_commit o_commit
);

    logic [LENGTH_BITS-1:0] r_field_count, n_field_count;
    logic [2:0]             r_header_count, n_header_count;
    logic [15:0]            r_record_id, n_record_id;
    logic [15:0]            r_record_size, n_record_size;
    logic [15:0]            r_payload_offset, n_payload_offset;
    logic [7:0]             r_stamp_flags, n_stamp_flags;
    logic [7:0]             r_uid_width, n_uid_width;
    logic [7:0]             r_gid_width, n_gid_width;
    logic [31:0]            r_pend [5];
    logic [31:0]            n_pend [5];

    zefp_pkg::t_slots  cur_slots;
    zefp_pkg::t_slots  new_slots;
    zefp_pkg::t_commit commit;
    logic [7:0]        stamp_flags_now;
    logic [15:0]       diff;
    logic [15:0]       idx;
    logic [15:0]       jdx;
    logic [16:0]       id_need;

    // flags as they stand after this beat while inside a timestamp payload
    assign stamp_flags_now = (r_payload_offset == 16'd0) ? i_data_byte : r_stamp_flags;

    assign cur_slots = zefp_pkg::stamp_slots(r_stamp_flags, r_record_size);
    assign new_slots = zefp_pkg::stamp_slots(stamp_flags_now, r_record_size);

    always_comb begin
        n_field_count    = r_field_count;
        n_header_count   = r_header_count;
        n_record_id      = r_record_id;
        n_record_size    = r_record_size;
        n_payload_offset = r_payload_offset;
        n_stamp_flags    = r_stamp_flags;
        n_uid_width      = r_uid_width;
        n_gid_width      = r_gid_width;
        for (int k = 0; k < 5; k++) begin
            n_pend[k] = r_pend[k];
        end
        commit  = '0;
        diff    = '0;
        idx     = r_payload_offset - 16'd2;
        jdx     = idx - {8'h00, r_uid_width} - 16'd1;
        id_need = '0;

        if (r_field_count != '1) begin
            n_field_count = r_field_count + LENGTH_BITS'(1);
            if (r_header_count < 3'd4) begin
                unique case (r_header_count[1:0])
                    2'd0: n_record_id        = {8'h00, i_data_byte};
                    2'd1: n_record_id[15:8]  = i_data_byte;
                    2'd2: n_record_size      = {8'h00, i_data_byte};
                    2'd3: n_record_size[15:8] = i_data_byte;
                endcase
                n_header_count = r_header_count + 3'd1;
                if (r_header_count == 3'd3) begin
                    n_payload_offset = '0;
                    n_stamp_flags    = '0;
                    n_uid_width      = '0;
                    n_gid_width      = '0;
                    for (int k = 0; k < 5; k++) begin
                        n_pend[k] = '0;
                    end
                    if (n_record_size == 16'd0) begin
                        n_header_count = 3'd0;
                    end
                end
            end else begin
                if (r_record_id == zefp_pkg::ID_STAMP) begin
                    if (r_payload_offset == 16'd0) begin
                        n_stamp_flags = i_data_byte;
                    end else begin
                        for (int k = 0; k < zefp_pkg::NUM_STAMPS; k++) begin
                            diff = r_payload_offset - {12'h000, cur_slots.start[k]};
                            if (cur_slots.present[k]
                                && r_payload_offset >= {12'h000, cur_slots.start[k]}
                                && diff < 16'd4) begin
                                n_pend[k][{diff[1:0], 3'b000} +: 8] =
                                    r_pend[k][{diff[1:0], 3'b000} +: 8] | i_data_byte;
                            end
                        end
                    end
                end else if (r_record_id == zefp_pkg::ID_UNIX
                             && r_payload_offset >= 16'd1) begin
                    if (r_payload_offset == 16'd1) begin
                        n_uid_width = i_data_byte;
                    end else if (idx < {8'h00, r_uid_width}) begin
                        if (idx < 16'd4) begin
                            n_pend[3][{idx[1:0], 3'b000} +: 8] =
                                r_pend[3][{idx[1:0], 3'b000} +: 8] | i_data_byte;
                        end
                    end else if (idx == {8'h00, r_uid_width}) begin
                        n_gid_width = i_data_byte;
                    end else if (jdx < {8'h00, r_gid_width} && jdx < 16'd4) begin
                        n_pend[4][{jdx[1:0], 3'b000} +: 8] =
                            r_pend[4][{jdx[1:0], 3'b000} +: 8] | i_data_byte;
                    end
                end

                n_payload_offset = r_payload_offset + 16'd1;

                // record complete
                if ({1'b0, r_payload_offset} + 17'd1 >= {1'b0, r_record_size}) begin
                    n_header_count = 3'd0;
                    if (r_record_id == zefp_pkg::ID_STAMP) begin
                        for (int k = 0; k < zefp_pkg::NUM_STAMPS; k++) begin
                            commit.stamp_take[k] = new_slots.present[k] && (n_pend[k] != '0);
                            commit.stamp_val[k]  = n_pend[k];
                        end
                    end else if (r_record_id == zefp_pkg::ID_UNIX) begin
                        id_need = 17'd3 + {9'h000, n_uid_width} + {9'h000, n_gid_width};
                        commit.unix_take = (id_need <= {1'b0, r_record_size});
                        commit.uid = (n_uid_width == 8'd0 || n_uid_width > 8'd8) ? '0 : n_pend[3];
                        commit.gid = (n_gid_width == 8'd0 || n_gid_width > 8'd8) ? '0 : n_pend[4];
                    end
                end
            end
        end
    end

    assign o_commit = commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last_byte)) begin
            r_field_count    <= '0;
            r_header_count   <= '0;
            r_record_id      <= '0;
            r_record_size    <= '0;
            r_payload_offset <= '0;
            r_stamp_flags    <= '0;
            r_uid_width      <= '0;
            r_gid_width      <= '0;
            for (int k = 0; k < 5; k++) begin
                r_pend[k] <= '0;
            end
        end else if (i_take) begin
            r_field_count    <= n_field_count;
            r_header_count   <= n_header_count;
            r_record_id      <= n_record_id;
            r_record_size    <= n_record_size;
            r_payload_offset <= n_payload_offset;
            r_stamp_flags    <= n_stamp_flags;
            r_uid_width      <= n_uid_width;
            r_gid_width      <= n_gid_width;
            for (int k = 0; k < 5; k++) begin
                r_pend[k] <= n_pend[k];
            end
        end
    end

    a_header_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_header_count <= 3'd4)
        else $error("header count out of range");

    a_offset_in_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_header_count == 3'd4 |-> r_payload_offset < r_record_size)
        else $error("payload offset past record size");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_last_byte |=> r_header_count == 3'd0 && r_field_count == '0)
        else $error("parser not cleared after last beat");

endmodule

@@ hdl/zefp_commit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zefp_commit
// committed values and flags; merges each record commit and forms the result
// on the final beat of the field
// ----------------------------------------------------------------------------
module zefp_commit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_last_byte,
    input  zefp_pkg::t_commit i_commit,
    output logic              o_emit,
    output zefp_pkg::t_result o_result
);

    logic [31:0] r_val [5];
    logic [31:0] n_val [5];
    logic [3:0]  r_has, n_has;

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            n_val[k] = r_val[k];
        end
        n_has = r_has;
        if (i_take) begin
            for (int k = 0; k < zefp_pkg::NUM_STAMPS; k++) begin
                if (i_commit.stamp_take[k]) begin
                    n_val[k]  = i_commit.stamp_val[k];
                    n_has[k]  = 1'b1;
                end
            end
            if (i_commit.unix_take) begin
                n_val[3] = i_commit.uid;
                n_val[4] = i_commit.gid;
                n_has[3] = 1'b1;
            end
        end
    end

    assign o_emit = i_take && i_last_byte;

    assign o_result.mod_time     = n_val[0];
    assign o_result.acc_time     = n_val[1];
    assign o_result.cre_time     = n_val[2];
    assign o_result.has_mod_time = n_has[0];
    assign o_result.has_acc_time = n_has[1];
    assign o_result.has_cre_time = n_has[2];
    assign o_result.has_unix_ids = n_has[3];
    assign o_result.user_id      = n_val[3];
    assign o_result.group_id     = n_val[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_emit) begin
            r_has <= '0;
            for (int k = 0; k < 5; k++) begin
                r_val[k] <= '0;
            end
        end else begin
            r_has <= n_has;
            for (int k = 0; k < 5; k++) begin
                r_val[k] <= n_val[k];
            end
        end
    end

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> r_has == 4'd0 && r_val[3] == '0 && r_val[4] == '0)
        else $error("committed state not cleared after result");

    a_no_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_take |=> r_has == $past(r_has))
        else $error("committed flags changed without a beat");

endmodule

@@ hdl/zefp_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zefp_out_stage
// result register between the parser and the output channel
// ----------------------------------------------------------------------------
module zefp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  zefp_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_can_load,
    output zefp_pkg::t_result o_result
);

    logic              r_valid;
    zefp_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("result loaded over an untaken beat");

endmodule
